>>> design/des_pkg.sv
package des_pkg;

  // Fixed field widths
  localparam int unsigned START_TRACK_W = 10;
  localparam int unsigned CFG_DATA_W    = 10;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned ID_W          = 16;
  localparam int unsigned STATUS_W      = 2;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_TRACK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DIR   = 1'b1;

  // Input modes
  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_SERVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_ADDED  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_SERVED = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_SHIFT,
    ST_OUT
  } des_state_t;

endpackage

>>> design/disk_elevator_scheduler_core.sv
// LOOK elevator scheduler: pending requests live in one synchronous RAM, packed in arrival order.
// Add or empty-serve word: out_valid rises the cycle after accept, then held until out_ready.
// Serve word: ST_SCAN reads every entry, ST_PICK chooses one, then ST_SHIFT moves the newer
// entries down over it (none when the newest entry is served) before out_valid rises. One word in
// flight: the next word is accepted the cycle after the result is taken.
// Sync active-low reset empties the table (fill count), zeroes ids, head track 0, upward.
module disk_elevator_scheduler_core
  import des_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned TRACK_BITS  = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,

  // request words
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [TRACK_BITS-1:0] in_track,

  // result words
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [ID_W-1:0]       out_request_id,
  output logic [TRACK_BITS-1:0] out_served_track,
  output logic                  out_head_direction,

  // register writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned IDXW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNTW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENT_W = ID_W + TRACK_BITS;

  // ---------------------------------------------------------------------------
  // Entry RAM: {id, track}. Entries 0..count-1 are live, oldest at 0.
  // Reads return in rd_data_r the cycle after mem_re.
  // ---------------------------------------------------------------------------
  logic [ENT_W-1:0] mem [TABLE_DEPTH];
  logic [ENT_W-1:0] rd_data_r;
  logic             mem_re;
  logic [IDXW-1:0]  rd_addr;
  logic             mem_we;
  logic [IDXW-1:0]  wr_addr;
  logic [ENT_W-1:0] wr_data;

  // ---------------------------------------------------------------------------
  // Control / state
  // ---------------------------------------------------------------------------
  des_state_t state_r, state_nxt;

  logic [CNTW-1:0]          count_r;      // fill count
  logic [ID_W-1:0]          next_id_r;
  logic [TRACK_BITS-1:0]    head_r;
  logic                     sweep_r;      // 1 = moving up

  logic [CNTW-1:0]          ptr_r;        // next RAM read address (scan and shift)
  logic                     rdv_r;        // rd_data_r holds a fresh read
  logic [IDXW-1:0]          rdidx_r;      // address behind rd_data_r

  // Running best candidates of the scan
  logic                     ab_found_r, bl_found_r;
  logic [TRACK_BITS-1:0]    ab_trk_r, bl_trk_r;
  logic [IDXW-1:0]          ab_idx_r, bl_idx_r;
  logic [ID_W-1:0]          ab_id_r, bl_id_r;

  // Result register
  logic [STATUS_W-1:0]      res_status_r;
  logic [ID_W-1:0]          res_id_r;
  logic [TRACK_BITS-1:0]    res_trk_r;

  logic                     in_fire;
  logic                     full;
  logic                     rd_issue;
  logic                     walk_done;
  logic [TRACK_BITS-1:0]    rd_trk;
  logic [ID_W-1:0]          rd_id;
  logic                     take_above;   // pick decision in ST_PICK
  logic [IDXW-1:0]          pick_idx;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
      rdidx_r   <= rd_addr;
    end
  end

  assign in_fire   = in_valid && in_ready;
  assign full      = (count_r == CNTW'(TABLE_DEPTH));
  assign rd_issue  = (ptr_r < count_r);
  assign walk_done = !rd_issue && !rdv_r;
  assign rd_trk    = rd_data_r[TRACK_BITS-1:0];
  assign rd_id     = rd_data_r[TRACK_BITS +: ID_W];

  // Up: lowest above, else fall back below. Down: highest at/below, else above.
  assign take_above = sweep_r ? ab_found_r : !bl_found_r;
  assign pick_idx   = take_above ? ab_idx_r : bl_idx_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_mode == MODE_ADD || count_r == '0) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (walk_done) state_nxt = ST_PICK;
      end
      ST_PICK: state_nxt = ST_SHIFT;
      ST_SHIFT: begin
        if (walk_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and RAM controls
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    mem_re    = 1'b0;
    rd_addr   = ptr_r[IDXW-1:0];
    mem_we    = 1'b0;
    wr_addr   = count_r[IDXW-1:0];
    wr_data   = {next_id_r, in_track};
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        // append at the tail
        mem_we   = in_valid && (in_mode == MODE_ADD) && !full;
      end
      ST_SCAN: begin
        mem_re = rd_issue;
      end
      ST_SHIFT: begin
        // read j+1, write it to j on the following cycle
        mem_re  = rd_issue;
        mem_we  = rdv_r;
        wr_addr = IDXW'(rdidx_r - 1'b1);
        wr_data = rd_data_r;
      end
      ST_OUT: begin
        out_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      next_id_r     <= '0;
      head_r        <= '0;
      sweep_r       <= 1'b1;
      ptr_r         <= '0;
      rdv_r         <= 1'b0;
      ab_found_r    <= 1'b0;
      bl_found_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdv_r   <= mem_re;

      // register writes; head/direction follow only while the table is empty
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_TRACK: begin
            if (count_r == '0) head_r <= TRACK_BITS'(cfg_data[START_TRACK_W-1:0]);
          end
          CFG_START_DIR: begin
            if (count_r == '0) sweep_r <= cfg_data[0];
          end
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            ptr_r      <= '0;
            ab_found_r <= 1'b0;
            bl_found_r <= 1'b0;
            if (in_mode == MODE_ADD && !full) begin
              count_r   <= count_r + 1'b1;
              next_id_r <= next_id_r + 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (rd_issue) ptr_r <= ptr_r + 1'b1;
          if (rdv_r) begin
            // strict compares keep the oldest of equal tracks
            if (rd_trk > head_r) begin
              if (!ab_found_r || rd_trk < ab_trk_r) begin
                ab_found_r <= 1'b1;
                ab_trk_r   <= rd_trk;
                ab_idx_r   <= rdidx_r;
                ab_id_r    <= rd_id;
              end
            end else begin
              if (!bl_found_r || rd_trk > bl_trk_r) begin
                bl_found_r <= 1'b1;
                bl_trk_r   <= rd_trk;
                bl_idx_r   <= rdidx_r;
                bl_id_r    <= rd_id;
              end
            end
          end
        end
        ST_PICK: begin
          ptr_r   <= CNTW'(pick_idx) + CNTW'(1);
          sweep_r <= take_above;
          head_r  <= take_above ? ab_trk_r : bl_trk_r;
        end
        ST_SHIFT: begin
          if (rd_issue) ptr_r <= ptr_r + 1'b1;
          if (walk_done) count_r <= count_r - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Result payload (no reset needed)
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_fire) begin
      if (in_mode == MODE_ADD) begin
        res_status_r <= full ? STAT_FULL : STAT_ADDED;
        res_id_r     <= full ? '0 : next_id_r;
        res_trk_r    <= in_track;
      end else begin
        res_status_r <= STAT_EMPTY;
        res_id_r     <= '0;
        res_trk_r    <= head_r;
      end
    end else if (state_r == ST_PICK) begin
      res_status_r <= STAT_SERVED;
      res_id_r     <= take_above ? ab_id_r : bl_id_r;
      res_trk_r    <= take_above ? ab_trk_r : bl_trk_r;
    end
  end

  assign out_status         = res_status_r;
  assign out_request_id     = res_id_r;
  assign out_served_track   = res_trk_r;
  assign out_head_direction = sweep_r;

`ifndef SYNTHESIS
  // fill count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(TABLE_DEPTH))
    else $error("fill count above table depth");

  // a serve only reaches pick with something pending, so a candidate exists
  a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PICK) |-> (ab_found_r || bl_found_r))
    else $error("pick with no candidate");

  // a served word removes exactly one entry
  a_serve_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid) && out_status == STAT_SERVED)
      |-> (count_r == $past(count_r) - 1'b1))
    else $error("serve did not drop one entry");

  // shift writes always land just below the entry being read back
  a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && mem_we && mem_re) |-> (wr_addr < rd_addr))
    else $error("shift write overtakes read");
`endif

endmodule

>>> verif/tb_disk_elevator_scheduler_core.sv
module tb_disk_elevator_scheduler_core;
  import des_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 16;
  localparam int TRACK_BITS  = 10;
  localparam int RANDOM_WORDS = 1300;
  // Serve word walks the table; drain hold-off covers it.
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT = 500000;

  // Sweep direction as seen on out_head_direction.
  localparam logic DIR_DOWN = 1'b0;
  localparam logic DIR_UP   = 1'b1;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [ID_W-1:0]       id;
    logic [TRACK_BITS-1:0] track;
    logic                  dir;
  } sched_reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_mode;
  logic [TRACK_BITS-1:0] in_track;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [ID_W-1:0]       out_request_id;
  logic [TRACK_BITS-1:0] out_served_track;
  logic                  out_head_direction;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  disk_elevator_scheduler_core #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .TRACK_BITS (TRACK_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_track          (in_track),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_request_id    (out_request_id),
    .out_served_track  (out_served_track),
    .out_head_direction(out_head_direction),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scheduler shadow: pending table packed in arrival order, head and sweep.
  // ---------------------------------------------------------------------------
  logic [TRACK_BITS-1:0] tbl_track [TABLE_DEPTH];
  logic [ID_W-1:0]       tbl_id    [TABLE_DEPTH];
  int                    tbl_count = 0;
  logic [ID_W-1:0]       id_ctr = '0;
  logic [TRACK_BITS-1:0] head_pos = '0;
  logic                  going_up = DIR_UP;
  logic [TRACK_BITS-1:0] reg_start_track = '0;
  logic                  reg_start_up = DIR_UP;

  sched_reply_t sched_replies[$];   // replies owed by the block, oldest first

  int  err_count = 0;
  int  words_sent = 0;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;
  bit  req_up = 1'b0;               // in_valid currently held high
  int  cycle_count = 0;
  logic [9:0] rx_tick = '0;

  // Oldest entry with the lowest track strictly above the head, or -1.
  function automatic int nearest_above();
    int best;
    best = -1;
    for (int i = 0; i < tbl_count; i++)
      if (tbl_track[i] > head_pos && (best < 0 || tbl_track[i] < tbl_track[best]))
        best = i;
    return best;
  endfunction

  // Oldest entry with the highest track at or below the head, or -1.
  function automatic int nearest_below();
    int best;
    best = -1;
    for (int i = 0; i < tbl_count; i++)
      if (tbl_track[i] <= head_pos && (best < 0 || tbl_track[i] > tbl_track[best]))
        best = i;
    return best;
  endfunction

  // Applies one accepted word to the shadow and returns the reply it owes.
  function automatic sched_reply_t schedule_word(logic mode, logic [TRACK_BITS-1:0] trk);
    sched_reply_t r;
    int pick;
    r = '0;
    if (mode == MODE_ADD) begin
      r.track = trk;
      if (tbl_count >= TABLE_DEPTH) begin
        r.status = STAT_FULL;   // dropped, no id consumed
      end else begin
        tbl_track[tbl_count] = trk;
        tbl_id[tbl_count] = id_ctr;
        tbl_count++;
        r.status = STAT_ADDED;
        r.id = id_ctr;
        id_ctr = id_ctr + 1'b1;
      end
    end else if (tbl_count == 0) begin
      r.status = STAT_EMPTY;
      r.track = head_pos;
    end else begin
      // LOOK: keep sweeping while work lies ahead, else turn around.
      if (going_up == DIR_UP) begin
        pick = nearest_above();
        if (pick < 0) begin
          pick = nearest_below();
          going_up = DIR_DOWN;
        end
      end else begin
        pick = nearest_below();
        if (pick < 0) begin
          pick = nearest_above();
          going_up = DIR_UP;
        end
      end
      r.status = STAT_SERVED;
      r.id = tbl_id[pick];
      r.track = tbl_track[pick];
      head_pos = tbl_track[pick];
      for (int i = pick; i + 1 < tbl_count; i++) begin
        tbl_track[i] = tbl_track[i + 1];
        tbl_id[i] = tbl_id[i + 1];
      end
      tbl_count--;
    end
    r.dir = going_up;
    return r;
  endfunction

  // Mostly extremes and tracks around the head, to hit the tie and turn cases.
  function automatic logic [TRACK_BITS-1:0] pick_track();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return head_pos;
      3: return head_pos + TRACK_BITS'($urandom_range(0, 6)) - TRACK_BITS'(3);
      default: return TRACK_BITS'($urandom_range(0, (1 << TRACK_BITS) - 1));
    endcase
  endfunction

  // Queue a reply at the tail of the owed list.
  task automatic owe_reply(sched_reply_t r);
    sched_replies.insert(sched_replies.size(), r);
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Request side: one word per call, bursts with random gaps between them.
  // Valid is only dropped at a burst end, so it never toggles within a step.
  // ---------------------------------------------------------------------------
  task automatic send_word(logic mode, logic [TRACK_BITS-1:0] trk);
    int gap;
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_track <= trk;
    req_up = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    owe_reply(schedule_word(mode, trk));
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if (gaps_on) begin
        // one gap in five is long and can let the block finish; short ones can land mid-scan
        gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
        in_valid <= 1'b0;
        req_up = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop sending and wait until every owed reply has been seen.
  task automatic wait_all_replies();
    if (req_up) begin
      in_valid <= 1'b0;
      req_up = 1'b0;
    end
    while (sched_replies.size() != 0) @(posedge clk);
  endtask

  // Only called with nothing in flight; head and sweep load only on an empty table.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_START_TRACK) begin
      reg_start_track = val[TRACK_BITS-1:0];
      if (tbl_count == 0) head_pos = reg_start_track;
    end else begin
      reg_start_up = val[0];
      if (tbl_count == 0) going_up = reg_start_up;
    end
    @(posedge clk);
  endtask

  // Fill to capacity, then offer a few more that must be dropped.
  task automatic overfill(int extra);
    repeat (TABLE_DEPTH - tbl_count + extra) send_word(MODE_ADD, pick_track());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_empty_serve();
    send_word(MODE_SERVE, '0);
    send_word(MODE_SERVE, '1);   // track ignored on serve
    wait_all_replies();
  endtask

  // Extremes and duplicates: up sweep, turn at the top, oldest-first on ties.
  task automatic test_sweep_extremes();
    send_word(MODE_ADD, '1);
    send_word(MODE_ADD, '0);
    send_word(MODE_ADD, '1);
    send_word(MODE_ADD, '0);
    send_word(MODE_ADD, TRACK_BITS'(512));
    repeat (5) send_word(MODE_SERVE, '0);
    wait_all_replies();
  endtask

  // Register writes on an empty table move the head; with work pending they do not.
  task automatic test_config_pending();
    write_reg(CFG_START_TRACK, CFG_DATA_W'((1 << TRACK_BITS) - 1));
    write_reg(CFG_START_DIR, CFG_DATA_W'(DIR_DOWN));
    send_word(MODE_ADD, TRACK_BITS'(5));
    send_word(MODE_ADD, TRACK_BITS'(1000));
    wait_all_replies();
    write_reg(CFG_START_TRACK, '0);
    write_reg(CFG_START_DIR, CFG_DATA_W'(DIR_UP));
    send_word(MODE_SERVE, '0);   // still down from the top: 1000
    send_word(MODE_SERVE, '0);   // then 5
    send_word(MODE_ADD, TRACK_BITS'(900));
    send_word(MODE_SERVE, '0);   // nothing at or below 5: turn up
    send_word(MODE_SERVE, '0);   // empty, head stays at 900
    wait_all_replies();
    write_reg(CFG_START_TRACK, '0);
    write_reg(CFG_START_DIR, CFG_DATA_W'(DIR_UP));
  endtask

  task automatic test_full_table();
    overfill(3);
    while (tbl_count > 0) send_word(MODE_SERVE, pick_track());
    send_word(MODE_SERVE, '0);
    wait_all_replies();
  endtask

  task automatic test_random_traffic();
    int start_words;
    int n;
    logic [TRACK_BITS-1:0] base;
    start_words = words_sent;
    while (words_sent - start_words < RANDOM_WORDS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0, 1: begin
          // mixed traffic, adds slightly favored so the table stays populated
          n = $urandom_range(5, 40);
          repeat (n)
            send_word(($urandom_range(0, 99) < 55) ? MODE_ADD : MODE_SERVE, pick_track());
        end
        2: begin
          // a batch of requests then serve it all and a bit past empty
          n = $urandom_range(1, TABLE_DEPTH);
          repeat (n) send_word(MODE_ADD, pick_track());
          repeat (n + $urandom_range(0, 2)) send_word(MODE_SERVE, pick_track());
        end
        3: begin
          overfill($urandom_range(1, 3));
          repeat ($urandom_range(1, TABLE_DEPTH)) send_word(MODE_SERVE, '0);
        end
        4: begin
          // tight cluster: many equal tracks, ties decided by age
          base = pick_track();
          repeat ($urandom_range(6, 20)) begin
            if ($urandom_range(0, 99) < 60)
              send_word(MODE_ADD, base + TRACK_BITS'($urandom_range(0, 2)));
            else
              send_word(MODE_SERVE, '0);
          end
        end
        default: begin
          wait_all_replies();
          case ($urandom_range(0, 3))
            0: write_reg(CFG_START_TRACK, '0);
            1: write_reg(CFG_START_TRACK, CFG_DATA_W'((1 << TRACK_BITS) - 1));
            default: write_reg(CFG_START_TRACK, CFG_DATA_W'($urandom_range(0, 1023)));
          endcase
          if ($urandom_range(0, 3) != 0)
            write_reg(CFG_START_DIR, CFG_DATA_W'($urandom_range(0, 1)));
        end
      endcase
      if ($urandom_range(0, 4) == 0) wait_all_replies();
    end
    wait_all_replies();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern cycles through always-ready, light, heavy and
  // coin-flip stalling, stepping with rx_tick[9:8].
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    case (rx_tick[9:8])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_ready <= (rx_tick[2:0] == 3'd0);
      default: out_ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // Every taken result word is matched against the oldest owed reply.
  always @(posedge clk) begin : reply_check
    sched_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sched_replies.size() == 0) begin
        report_mismatch($sformatf("result word with nothing owed: status %0d id %0d track %0d",
                                  out_status, out_request_id, out_served_track));
      end else begin
        want = sched_replies.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
        if (out_request_id !== want.id)
          report_mismatch($sformatf("request_id got %0d want %0d", out_request_id, want.id));
        if (out_served_track !== want.track)
          report_mismatch($sformatf("served_track got %0d want %0d",
                                    out_served_track, want.track));
        if (out_head_direction !== want.dir)
          report_mismatch($sformatf("head_direction got %0d want %0d",
                                    out_head_direction, want.dir));
      end
    end
  end

  // Watchdog: worst case is well under this even with every stall stacked.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_disk_elevator_scheduler_core failed");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_mode   <= MODE_ADD;
    in_track  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_START_TRACK;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_serve();
    test_sweep_extremes();
    test_config_pending();
    test_full_table();
    test_random_traffic();

    wait_all_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("tb_disk_elevator_scheduler_core passed");
    else
      $display("tb_disk_elevator_scheduler_core failed");
    $finish;
  end

endmodule
